>>> rtl/core/baro_cmp_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Types and constants shared by the compensation pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package baro_cmp_pkg;

  localparam int RAW_W   = 24;  // raw conversion width
  localparam int COEF_W  = 16;  // calibration coefficient width
  localparam int IDX_W   = 3;   // configuration register index width
  localparam int TEMP_W  = 20;  // internal temperature width, signed
  localparam int WIDE_W  = 40;  // offset and sensitivity width, signed
  localparam int T2_W    = 17;  // second-order temperature term width
  localparam int TOUT_W  = 19;  // output temperature width
  localparam int POUT_W  = 32;  // output pressure width

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_PRESSURE_SENSITIVITY  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESSURE_OFFSET       = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENSITIVITY_TEMP_COEF = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TEMP_COEF      = 3'd3;
  localparam logic [IDX_W-1:0] REG_REFERENCE_TEMP        = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_COEF             = 3'd5;

  // Temperature thresholds in 0.01 C.
  localparam logic signed [TEMP_W-1:0] TEMP_BASE    = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] COLD_LIMIT   = -20'sd1500;
  localparam logic signed [TEMP_W-1:0] COLD_OFS     = 20'sd1500;
  localparam logic signed [TEMP_W-1:0] TEMP_OUT_MIN = -20'sd262144;
  localparam logic signed [TEMP_W-1:0] TEMP_OUT_MAX = 20'sd262143;

  typedef struct packed {
    logic [COEF_W-1:0] pressure_sensitivity;
    logic [COEF_W-1:0] pressure_offset;
    logic [COEF_W-1:0] sensitivity_temp_coef;
    logic [COEF_W-1:0] offset_temp_coef;
    logic [COEF_W-1:0] reference_temp;
    logic [COEF_W-1:0] temp_coef;
  } cfg_t;

  // First-order results handed to the low-temperature correction.
  typedef struct packed {
    logic        [RAW_W-1:0]  raw_pressure;
    logic signed [TEMP_W-1:0] temp;
    logic        [T2_W-1:0]   t2;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
  } first_t;

  // Fully corrected terms handed to the pressure stage.
  typedef struct packed {
    logic        [RAW_W-1:0]  raw_pressure;
    logic signed [TEMP_W-1:0] temp;
    logic signed [WIDE_W-1:0] off;
    logic signed [WIDE_W-1:0] sens;
  } comp_t;

endpackage

`default_nettype wire

>>> rtl/core/baro_cmp_first.sv
// ----------------------------------------------------------------------------
// First-order compensation
// Three stages: temperature difference, coefficient products, then the
// first-order temperature, offset and sensitivity.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_cmp_first
  import baro_cmp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  input  wire logic [RAW_W-1:0] raw_pressure,
  input  wire logic [RAW_W-1:0] raw_temperature,
  output logic                  out_valid,
  output first_t                out
);

  logic v1, v2, v3;

  logic signed [24:0] dt1;
  logic [RAW_W-1:0]   rp1, rp2;
  logic signed [41:0] m6, m4, m3;
  logic [47:0]        msq;
  logic signed [49:0] sq;
  logic signed [41:0] m6_b, m4_b, m3_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    sq   = dt1 * dt1;
    // Bias negative values so the shift truncates toward zero.
    m6_b = m6 + $signed({19'd0, {23{m6[41]}}});
    m4_b = m4 + $signed({35'd0, {7{m4[41]}}});
    m3_b = m3 + $signed({34'd0, {8{m3[41]}}});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dt1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cfg.reference_temp, 8'h00});
      rp1 <= raw_pressure;

      m6  <= dt1 * $signed({1'b0, cfg.temp_coef});
      m4  <= dt1 * $signed({1'b0, cfg.offset_temp_coef});
      m3  <= dt1 * $signed({1'b0, cfg.sensitivity_temp_coef});
      msq <= sq[47:0];
      rp2 <= rp1;

      out.raw_pressure <= rp2;
      out.temp <= TEMP_BASE + $signed({m6_b[41], m6_b[41:23]});
      out.off  <= $signed({8'd0, cfg.pressure_offset, 16'd0})
                + $signed({{5{m4_b[41]}}, m4_b[41:7]});
      out.sens <= $signed({9'd0, cfg.pressure_sensitivity, 15'd0})
                + $signed({{6{m3_b[41]}}, m3_b[41:8]});
      out.t2   <= msq[47:31];
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

>>> rtl/core/baro_cmp_second.sv
// ----------------------------------------------------------------------------
// Low-temperature correction
// Three stages: squared temperature distances, correction terms, and their
// subtraction from the first-order results.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_cmp_second
  import baro_cmp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire first_t in,
  output logic        out_valid,
  output comp_t       out
);

  logic v4, v5, v6;

  first_t p4, p5;
  logic   low4, cold4;
  logic [35:0] sq_lo4, sq_vc4;
  logic [WIDE_W-1:0] off2_5, sens2_5;
  logic [T2_W-1:0]   t2_5;

  logic signed [TEMP_W-1:0] dlow, dvc;
  logic signed [39:0] prod_lo, prod_vc;
  logic [38:0] five_lo, seven_vc;
  logic [39:0] eleven_vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_comb begin
    dlow      = in.temp - TEMP_BASE;
    dvc       = in.temp + COLD_OFS;
    prod_lo   = dlow * dlow;
    prod_vc   = dvc * dvc;
    five_lo   = {3'd0, sq_lo4} + {1'b0, sq_lo4, 2'd0};
    seven_vc  = {sq_vc4, 3'd0} - {3'd0, sq_vc4};
    eleven_vc = {1'b0, sq_vc4, 3'd0} + {3'd0, sq_vc4, 1'b0} + {4'd0, sq_vc4};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4     <= in;
      low4   <= in.temp < TEMP_BASE;
      cold4  <= in.temp < COLD_LIMIT;
      sq_lo4 <= prod_lo[35:0];
      sq_vc4 <= prod_vc[35:0];

      p5 <= p4;
      if (low4) begin
        off2_5  <= {2'd0, five_lo[38:1]} + (cold4 ? {1'b0, seven_vc} : 40'd0);
        sens2_5 <= {3'd0, five_lo[38:2]} + (cold4 ? {1'b0, eleven_vc[39:1]} : 40'd0);
        t2_5    <= p4.t2;
      end else begin
        off2_5  <= '0;
        sens2_5 <= '0;
        t2_5    <= '0;
      end

      out.raw_pressure <= p5.raw_pressure;
      out.temp <= p5.temp - $signed({3'd0, t2_5});
      out.off  <= p5.off - $signed(off2_5);
      out.sens <= p5.sens - $signed(sens2_5);
    end
  end

  assign out_valid = v6;

  // The very-cold correction only ever rides on top of the low-temperature one.
  a_cold_implies_low: assert property (@(posedge clk) disable iff (rst)
    v4 && cold4 |-> low4)
    else $error("cold flag set without low-temperature flag");

endmodule

`default_nettype wire

>>> rtl/core/baro_cmp_press.sv
// ----------------------------------------------------------------------------
// Pressure computation
// Four stages: split product of raw pressure and sensitivity, product sum,
// scale and offset subtraction, final scale and output formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_cmp_press
  import baro_cmp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic                in_valid,
  input  wire comp_t               in,
  output logic                     out_valid,
  output logic signed [TOUT_W-1:0] temperature_centi,
  output logic signed [POUT_W-1:0] pressure_centi
);

  logic v7, v8, v9, v10;

  logic [43:0]          pl7;
  logic signed [44:0]   ph7;
  logic signed [WIDE_W-1:0] off7, off8;
  logic [TOUT_W-1:0]    tc7, tc8, tc9;
  logic signed [63:0]   prod8, prod_b;
  logic signed [43:0]   diff9, diff_b;
  logic [TOUT_W-1:0]    tsat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (adv) begin
      v7  <= in_valid;
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_comb begin
    if (in.temp < TEMP_OUT_MIN) begin
      tsat = TEMP_OUT_MIN[TOUT_W-1:0];
    end else if (in.temp > TEMP_OUT_MAX) begin
      tsat = TEMP_OUT_MAX[TOUT_W-1:0];
    end else begin
      tsat = in.temp[TOUT_W-1:0];
    end
    prod_b = prod8 + $signed({43'd0, {21{prod8[63]}}});
    diff_b = diff9 + $signed({29'd0, {15{diff9[43]}}});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Sensitivity split into a signed upper half and an unsigned lower half.
      pl7  <= in.raw_pressure * in.sens[19:0];
      ph7  <= $signed({1'b0, in.raw_pressure}) * $signed(in.sens[39:20]);
      off7 <= in.off;
      tc7  <= tsat;

      prod8 <= $signed({ph7[43:0], 20'd0} + {20'd0, pl7});
      off8  <= off7;
      tc8   <= tc7;

      diff9 <= $signed({prod_b[63], prod_b[63:21]}) - $signed({{4{off8[39]}}, off8});
      tc9   <= tc8;

      // The scaled pressure spans 29 bits at most, so it never reaches the
      // 32-bit limits and sign extension is exact.
      pressure_centi    <= $signed({{3{diff_b[43]}}, diff_b[43:15]});
      temperature_centi <= $signed(tc9);
    end
  end

  assign out_valid = v10;

  a_prod_fits: assert property (@(posedge clk) disable iff (rst)
    v8 |-> prod8[63] == prod8[62])
    else $error("raw pressure times sensitivity overflowed");

endmodule

`default_nettype wire

>>> rtl/core/baro_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation top level
// Second-order compensation of raw pressure and temperature conversions.
// ----------------------------------------------------------------------------
// Throughput: one transfer per cycle; the ten register stages all move
// together and a stall on the output holds every stage in place.
// Reset (rst, synchronous, active high) clears all six coefficients and
// every pipeline valid bit; the block accepts input right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sensor_compensation_top
  import baro_cmp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,

  // Configuration write port.
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_W-1:0] cfg_data,

  // Input stream.
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [47:0]       s_tdata,  // [23:0] raw_pressure, [47:24] raw_temperature

  // Output stream.
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [55:0]            m_tdata   // [18:0] temperature_centi,
                                           // [50:19] pressure_centi, [55:51] zero
);

  cfg_t   cfg;
  logic   adv;
  logic   first_valid, second_valid;
  first_t first_out;
  comp_t  second_out;
  logic signed [TOUT_W-1:0] temperature_centi;
  logic signed [POUT_W-1:0] pressure_centi;

  // Coefficient registers. Writes to indexes beyond the last register are
  // dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESSURE_SENSITIVITY:  cfg.pressure_sensitivity  <= cfg_data;
        REG_PRESSURE_OFFSET:       cfg.pressure_offset       <= cfg_data;
        REG_SENSITIVITY_TEMP_COEF: cfg.sensitivity_temp_coef <= cfg_data;
        REG_OFFSET_TEMP_COEF:      cfg.offset_temp_coef      <= cfg_data;
        REG_REFERENCE_TEMP:        cfg.reference_temp        <= cfg_data;
        REG_TEMP_COEF:             cfg.temp_coef             <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances whenever the output register is empty or its
  // result is being transferred this cycle. Bubbles travel as cleared valid
  // bits, so a held stage never loses or repeats an item.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  baro_cmp_first u_first (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .cfg             (cfg),
    .in_valid        (s_tvalid),
    .raw_pressure    (s_tdata[23:0]),
    .raw_temperature (s_tdata[47:24]),
    .out_valid       (first_valid),
    .out             (first_out)
  );

  baro_cmp_second u_second (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (first_valid),
    .in        (first_out),
    .out_valid (second_valid),
    .out       (second_out)
  );

  // The last stage of this unit doubles as the output register.
  baro_cmp_press u_press (
    .clk               (clk),
    .rst               (rst),
    .adv               (adv),
    .in_valid          (second_valid),
    .in                (second_out),
    .out_valid         (m_tvalid),
    .temperature_centi (temperature_centi),
    .pressure_centi    (pressure_centi)
  );

  assign m_tdata = {5'd0, pressure_centi, temperature_centi};

  // A reset must flush every item in flight.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> tb/sv/tb_baro_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric sensor compensation testbench
// Drives raw pressure and temperature pairs through the compensation block
// under several calibration sets and compares each result transfer with an
// in-bench model of the second-order compensation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_baro_sensor_compensation_top;
  timeunit 1ns;
  timeprecision 1ps;

  import baro_cmp_pkg::*;

  localparam int LATENCY         = 10;
  localparam int FLUSH_CYCLES    = 2 * LATENCY;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int NUM_COEFS       = 6;
  localparam int NUM_ROWS        = 36;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 94;
  localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;

  // Register indexes past the last coefficient; a write there must be ignored.
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Temperature limits in 0.01 C and output saturation bounds.
  localparam longint ROOM_CENTI  = 2000;
  localparam longint COLD_CENTI  = -1500;
  localparam longint TEMP_SAT_LO = -262144;
  localparam longint TEMP_SAT_HI = 262143;
  localparam longint PRES_SAT_LO = -64'sd2147483648;
  localparam longint PRES_SAT_HI = 64'sd2147483647;

  // A calibration set of the kind found in real parts, used for one phase.
  localparam logic [COEF_W-1:0] TYPICAL_CAL [NUM_COEFS] =
    '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};

  typedef struct packed {
    logic signed [TOUT_W-1:0] temp;
    logic signed [POUT_W-1:0] pres;
  } reading_t;

  // The directed script mixes register writes with samples. A typed row
  // carries its own expected reading; a sample row is checked by the model.
  typedef enum int {ROW_WRITE, ROW_SAMPLE, ROW_TYPED} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [IDX_W-1:0]         idx;
    logic [COEF_W-1:0]        coef;
    logic [RAW_W-1:0]         raw_p;
    logic [RAW_W-1:0]         raw_t;
    logic signed [TOUT_W-1:0] temp;
    logic signed [POUT_W-1:0] pres;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [47:0]       s_tdata;  // [23:0] raw_pressure, [47:24] raw_temperature
  logic              m_tvalid;
  logic              m_tready;
  logic [55:0]       m_tdata;  // [18:0] temperature_centi, [50:19] pressure_centi,
                               // [55:51] zero

  logic signed [TOUT_W-1:0] out_temp;
  logic signed [POUT_W-1:0] out_pres;
  assign out_temp = m_tdata[18:0];
  assign out_pres = m_tdata[50:19];

  // The bench keeps its own copy of the six coefficients. It is only
  // changed while nothing is in flight, so a reading can be predicted at
  // the moment its input transfer is accepted.
  logic [COEF_W-1:0] cal [NUM_COEFS];
  reading_t          readings_due [$];
  reading_t          want;
  row_t              script [NUM_ROWS];
  bit                row_typed;
  reading_t          row_reading;
  bit                steady = 1'b0;  // when set, neither side idles
  int                hold_cycles = 0;
  int                fail_count = 0;
  int                cycle_count;

  baro_sensor_compensation_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compensated reading for one raw pair under the current coefficients.
  // All arithmetic is 64-bit signed, and SystemVerilog division truncates
  // toward zero just as the sensor's integer recipe expects.
  function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
                                          input logic [RAW_W-1:0] raw_t);
    longint d1, dt, temp, off, sens, t2, dlow, dvc, off2, sens2, p;
    reading_t r;
    d1   = longint'(raw_p);
    dt   = longint'(raw_t) - longint'(cal[REG_REFERENCE_TEMP]) * 256;
    temp = ROOM_CENTI + (dt * longint'(cal[REG_TEMP_COEF])) / 8388608;
    off  = longint'(cal[REG_PRESSURE_OFFSET]) * 65536
         + (longint'(cal[REG_OFFSET_TEMP_COEF]) * dt) / 128;
    sens = longint'(cal[REG_PRESSURE_SENSITIVITY]) * 32768
         + (longint'(cal[REG_SENSITIVITY_TEMP_COEF]) * dt) / 256;
    // Below room temperature the second-order terms apply; the very cold
    // extra terms are judged on the first-order temperature.
    if (temp < ROOM_CENTI) begin
      t2    = (dt * dt) / 64'sd2147483648;
      dlow  = temp - ROOM_CENTI;
      off2  = (5 * dlow * dlow) / 2;
      sens2 = (5 * dlow * dlow) / 4;
      if (temp < COLD_CENTI) begin
        dvc   = temp - COLD_CENTI;
        off2  = off2 + 7 * dvc * dvc;
        sens2 = sens2 + (11 * dvc * dvc) / 2;
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end
    p = ((d1 * sens) / 2097152 - off) / 32768;
    if (temp < TEMP_SAT_LO) temp = TEMP_SAT_LO;
    else if (temp > TEMP_SAT_HI) temp = TEMP_SAT_HI;
    if (p < PRES_SAT_LO) p = PRES_SAT_LO;
    else if (p > PRES_SAT_HI) p = PRES_SAT_HI;
    r.temp = temp[TOUT_W-1:0];
    r.pres = p[POUT_W-1:0];
    return r;
  endfunction

  // Idle stretch length: mostly a few cycles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw_pressure();
    case ($urandom_range(0, 9))
      7:       return '0;
      8:       return RAW_MAX;
      9:       return RAW_W'($urandom_range(7000000, 10000000));
      default: return RAW_W'($urandom_range(0, RAW_MAX));
    endcase
  endfunction

  // Raw temperatures are steered around the reference point and onto the
  // room and very cold thresholds, so that all three correction regimes and
  // the edges between them get plenty of traffic.
  function automatic logic [RAW_W-1:0] pick_raw_temp();
    longint ref_pt, dt, v, q;
    ref_pt = longint'(cal[REG_REFERENCE_TEMP]) * 256;
    case ($urandom_range(0, 9))
      4, 5, 6: v = ref_pt + longint'($urandom_range(0, 1 << 22)) - (1 << 21);
      7, 8: begin
        if (cal[REG_TEMP_COEF] == 0) begin
          v = $urandom_range(0, RAW_MAX);
        end else begin
          case ($urandom_range(0, 3))
            0:       q = 0;
            1:       q = -1;
            2:       q = COLD_CENTI - ROOM_CENTI;
            default: q = COLD_CENTI - ROOM_CENTI - 1;
          endcase
          dt = (q * 8388608) / longint'(cal[REG_TEMP_COEF]);
          v  = ref_pt + dt + longint'($urandom_range(0, 4)) - 2;
        end
      end
      9:       v = $urandom_range(0, 1) ? longint'(RAW_MAX) : 0;
      default: v = $urandom_range(0, RAW_MAX);
    endcase
    if (v < 0) v = 0;
    else if (v > longint'(RAW_MAX)) v = RAW_MAX;
    return v[RAW_W-1:0];
  endfunction

  // Stop offering input and wait until every predicted reading is back.
  task automatic drain_results();
    s_tvalid = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
  endtask

  // Register writes happen only with the pipeline empty. The enable is
  // left high here and dropped by the next sample transfer.
  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    if (idx < NUM_COEFS) cal[idx] = value;
    @(negedge clk);
  endtask

  // Offer one sample and hold it until the transfer happens. Afterwards the
  // valid either stays high for a back-to-back sample or drops for a gap.
  task automatic send_sample(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
                             input bit typed, input reading_t typed_val);
    int gap;
    cfg_we      = 1'b0;
    row_typed   = typed;
    row_reading = typed_val;
    s_tdata     = {raw_t, raw_p};
    s_tvalid    = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Every accepted input transfer queues the reading it must produce.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      readings_due.push_back(row_typed ? row_reading
                                       : compensate(s_tdata[23:0], s_tdata[47:24]));
    end
  end

  // Every output transfer is matched against the oldest queued reading.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (readings_due.size() == 0) begin
        $error("unexpected result transfer: temperature_centi %0d, pressure_centi %0d",
               out_temp, out_pres);
        fail_count++;
      end else begin
        want = readings_due.pop_front();
        if (out_temp !== want.temp) begin
          $error("temperature_centi: expected %0d, got %0d", want.temp, out_temp);
          fail_count++;
        end
        if (out_pres !== want.pres) begin
          $error("pressure_centi: expected %0d, got %0d", want.pres, out_pres);
          fail_count++;
        end
        if (m_tdata[55:51] !== 5'd0) begin
          $error("padding: expected 0, got %0d", m_tdata[55:51]);
          fail_count++;
        end
      end
    end
  end

  // Output side back-pressure, changed on the falling edge.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else begin
        m_tready = 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) hold_cycles = idle_len();
      end
    end
  end

  // Watchdog: a run that never drains ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int               i, ph, n;
    logic [COEF_W-1:0] v;

    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    row_typed   = 1'b0;
    row_reading = '0;
    for (i = 0; i < NUM_COEFS; i++) cal[i] = '0;

    script = '{
      // Uncalibrated: every coefficient is zero, so the temperature sits at
      // 20.00 C and the pressure at zero whatever the raw values are.
      '{ROW_TYPED,  '0, '0, 24'h000000, 24'h000000, 2000, 0},
      '{ROW_TYPED,  '0, '0, 24'hFFFFFF, 24'hFFFFFF, 2000, 0},
      '{ROW_TYPED,  '0, '0, 24'hAAAAAA, 24'h555555, 2000, 0},
      '{ROW_TYPED,  '0, '0, 24'h555555, 24'hAAAAAA, 2000, 0},
      // Writes past the last register must leave the coefficients alone.
      '{ROW_WRITE,  REG_SPARE_6, 16'hFFFF, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_SPARE_7, 16'hFFFF, '0, '0, 0, 0},
      '{ROW_TYPED,  '0, '0, 24'h123456, 24'h654321, 2000, 0},
      // Offset alone: pressure is minus the offset scaled up by 2^16, then down by 2^15.
      '{ROW_WRITE,  REG_PRESSURE_OFFSET, 16'hFFFF, '0, '0, 0, 0},
      '{ROW_TYPED,  '0, '0, 24'h000000, 24'h000000, 2000, -131070},
      '{ROW_TYPED,  '0, '0, 24'hFFFFFF, 24'h000000, 2000, -131070},
      // A realistic calibration across warm, cool, very cold and hot.
      '{ROW_WRITE,  REG_PRESSURE_SENSITIVITY,  16'd40127, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_PRESSURE_OFFSET,       16'd36924, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_SENSITIVITY_TEMP_COEF, 16'd23317, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_OFFSET_TEMP_COEF,      16'd23282, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_REFERENCE_TEMP,        16'd33464, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_TEMP_COEF,             16'd28312, '0, '0, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'd9085466, 24'd8569150, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'd9085466, 24'd8000000, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'd9085466, 24'd7000000, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'd9085466, 24'h000000, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'h000000, 24'hFFFFFF, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 24'h000000, 0, 0},
      // Every coefficient at its maximum.
      '{ROW_WRITE,  REG_PRESSURE_SENSITIVITY,  16'hFFFF, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_PRESSURE_OFFSET,       16'hFFFF, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_SENSITIVITY_TEMP_COEF, 16'hFFFF, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_OFFSET_TEMP_COEF,      16'hFFFF, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_REFERENCE_TEMP,        16'hFFFF, '0, '0, 0, 0},
      '{ROW_WRITE,  REG_TEMP_COEF,             16'hFFFF, '0, '0, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'h000000, 24'h000000, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 24'hFFFFFF, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 24'h000000, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'h000000, 24'hFFFFFF, 0, 0},
      // Just at and just below 20.00 C, then at and just below -15.00 C.
      '{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 24'd16776832, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'hFFFFFF, 24'd16776831, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'd800000, 24'd16328826, 0, 0},
      '{ROW_SAMPLE, '0, '0, 24'd800000, 24'd16328825, 0, 0}
    };

    // Synchronous reset, asserted from the start and released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < NUM_ROWS; i++) begin
      case (script[i].kind)
        ROW_WRITE:  write_coef(script[i].idx, script[i].coef);
        ROW_SAMPLE: send_sample(script[i].raw_p, script[i].raw_t, 1'b0, '0);
        default:    send_sample(script[i].raw_p, script[i].raw_t, 1'b1,
                                '{temp: script[i].temp, pres: script[i].pres});
      endcase
    end

    // Random phases. Each starts from an empty pipeline with a fresh
    // calibration: all zero, all ones, the realistic set, then random sets
    // that lean toward the extremes. A stray write to a spare index follows
    // now and then and must change nothing.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      for (i = 0; i < NUM_COEFS; i++) begin
        case (ph)
          0:       v = '0;
          1:       v = 16'hFFFF;
          2:       v = TYPICAL_CAL[i];
          default: begin
            case ($urandom_range(0, 9))
              0:       v = '0;
              1:       v = 16'hFFFF;
              default: v = COEF_W'($urandom_range(0, 16'hFFFF));
            endcase
          end
        endcase
        write_coef(i[IDX_W-1:0], v);
      end
      if ($urandom_range(0, 1)) begin
        write_coef($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                   COEF_W'($urandom_range(0, 16'hFFFF)));
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Flip into and out of stretches where neither side idles.
        if ($urandom_range(0, 99) < 3) steady = !steady;
        // Occasionally hold the input until every reading is back.
        if ($urandom_range(0, 199) == 0) drain_results();
        send_sample(pick_raw_pressure(), pick_raw_temp(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> baro_sensor_compensation_top.f
rtl/core/baro_cmp_pkg.sv
rtl/core/baro_cmp_first.sv
rtl/core/baro_cmp_second.sv
rtl/core/baro_cmp_press.sv
rtl/core/baro_sensor_compensation_top.sv
tb/sv/tb_baro_sensor_compensation_top.sv
